[design/temp_sensor_average_window_alarm_unit_defines.svh]
// Assertion macros shared by the temperature alarm unit and its alarm submodule.
// Each file that asserts includes this header; the macros expect clk and rst_n in scope.
`ifndef TEMP_SENSOR_AVERAGE_WINDOW_ALARM_UNIT_DEFINES_SVH
`define TEMP_SENSOR_AVERAGE_WINDOW_ALARM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tsa_pkg.sv]
// Shared types and constants of the temperature averaging and window alarm unit.
// Used by every module of the block; depends on nothing.
package tsa_pkg;

  localparam int TEMP_W      = 17;
  localparam int GAIN_W      = 16;
  localparam int HYST_W      = 16;
  localparam int BASE_W      = 16;
  localparam int SUM_W       = 18;
  localparam int MUL_CNT_W   = 4;
  localparam int DIV_CNT_W   = 5;
  localparam int SAMPLE_W    = 10;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 17;

  // Full-scale reading maps to 100 degrees in 1/256 degree units.
  localparam int BASE_SCALE  = 25600;
  // Zero point of the half-scale offset sensor, 50 degrees.
  localparam int HALF_SCALE  = 12800;

  localparam logic [TEMP_W-1:0] TEMP_MAX = 17'h0FFFF;
  localparam logic [TEMP_W-1:0] TEMP_MIN = 17'h10000;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_TYPE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_Q8     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_T    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LOWER_LIMIT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_HYSTERESIS  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0] RST_GAIN_Q8     = 16'd256;
  localparam logic [TEMP_W-1:0] RST_UPPER_LIMIT = 17'd7680;
  localparam logic [TEMP_W-1:0] RST_LOWER_LIMIT = 17'd2560;
  localparam logic [HYST_W-1:0] RST_HYSTERESIS  = 16'd256;

  typedef struct packed {
    logic              sensor_type;
    logic [GAIN_W-1:0] gain_q8;
    logic [TEMP_W-1:0] offset_t;
  } cal_cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] upper_limit;
    logic [TEMP_W-1:0] lower_limit;
    logic [HYST_W-1:0] hysteresis;
  } win_cfg_t;

  typedef struct packed {
    logic active;
    logic range_event;
  } alarm_stat_t;

  // Result payload, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic              range_event;
    logic              alarm_active;
    logic [TEMP_W-1:0] avg_temp;
    logic [TEMP_W-1:0] inst_temp;
  } out_pay_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INST,
    S_CMP,
    S_DIV,
    S_AVG,
    S_OUT
  } tsa_state_t;

endpackage

[design/tsa_div.sv]
// Bit-serial restoring divider of the window sum by the constant window length.
// Depends on tsa_pkg for the sum width.
module tsa_div
  import tsa_pkg::*;
#(
  parameter int SAMPLES_PER_AVG = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  output logic             busy,
  output logic [SUM_W-1:0] quotient
);

  // The partial remainder stays below the divisor; one extra bit holds the trial value.
  localparam int REM_W = $clog2(SAMPLES_PER_AVG) + 2;
  localparam logic [REM_W-1:0] DIVISOR = REM_W'(SAMPLES_PER_AVG);
  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(SUM_W - 1);

  logic [SUM_W-1:0]     dvd_r, dvd_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  always_comb begin
    trial    = {rem_r[REM_W-2:0], dvd_r[SUM_W-1]};
    fits     = trial >= DIVISOR;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Dividend bits leave at the top while quotient bits enter at the bottom.
      dvd_nxt = {dvd_r[SUM_W-2:0], fits};
      rem_nxt = fits ? trial - DIVISOR : trial;
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

[design/tsa_conv.sv]
// Reading to temperature conversion: base value, bit-serial gain multiply,
// offset add and saturation. Depends on tsa_pkg for widths and the calibration struct.
module tsa_conv
  import tsa_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ADC_BITS-1:0] reading,
  input  cal_cfg_t            cal,
  output logic                done,
  output logic [TEMP_W-1:0]   temp
);

  localparam int FULL_W = ADC_BITS + 15;
  localparam logic [MUL_CNT_W-1:0] LAST_STEP = MUL_CNT_W'(GAIN_W - 1);

  logic [FULL_W-1:0]    full;
  logic [14:0]          base_u;
  logic [BASE_W-1:0]    base_s;

  logic [BASE_W-1:0]    mcand_r, mcand_nxt;
  logic [BASE_W:0]      hi_r, hi_nxt;
  logic [GAIN_W-1:0]    lo_r, lo_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 fin_r, fin_nxt;
  logic                 done_r, done_nxt;
  logic [TEMP_W-1:0]    temp_r, temp_nxt;

  logic [BASE_W:0]      addend;
  logic [BASE_W:0]      psum;
  logic [25:0]          tsum;
  logic                 in_range;

  // Base value: reading scaled so that full scale is 100 degrees, less 50 degrees
  // for the half-scale offset sensor. It always fits 16 bits signed.
  always_comb begin
    full   = FULL_W'(reading) * FULL_W'(BASE_SCALE);
    base_u = full[FULL_W-1:ADC_BITS];
    base_s = {1'b0, base_u} - (cal.sensor_type ? BASE_W'(HALF_SCALE) : BASE_W'(0));
  end

  // Shift-and-add over the gain bits, least significant first. The running high
  // half never grows past the multiplicand, so 17 bits suffice.
  always_comb begin
    addend = lo_r[0] ? {mcand_r[BASE_W-1], mcand_r} : '0;
    psum   = hi_r + addend;
    // Product shifted right by 8 is the high half and the top byte of the low half.
    tsum   = {hi_r[BASE_W], hi_r, lo_r[GAIN_W-1:8]}
             + {{9{cal.offset_t[TEMP_W-1]}}, cal.offset_t};
    in_range = (&tsum[25:16]) || !(|tsum[25:16]);
  end

  always_comb begin
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    fin_nxt   = 1'b0;
    done_nxt  = 1'b0;
    temp_nxt  = temp_r;
    if (start) begin
      mcand_nxt = base_s;
      hi_nxt    = '0;
      lo_nxt    = cal.gain_q8;
      cnt_nxt   = '0;
      run_nxt   = 1'b1;
    end else if (run_r) begin
      hi_nxt  = {psum[BASE_W], psum[BASE_W:1]};
      lo_nxt  = {psum[0], lo_r[GAIN_W-1:1]};
      cnt_nxt = cnt_r + MUL_CNT_W'(1);
      if (cnt_r == LAST_STEP) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end
    if (fin_r) begin
      done_nxt = 1'b1;
      if (in_range) begin
        temp_nxt = tsum[TEMP_W-1:0];
      end else begin
        temp_nxt = tsum[25] ? TEMP_MIN : TEMP_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    cnt_r   <= cnt_nxt;
    temp_r  <= temp_nxt;
  end

  assign done = done_r;
  assign temp = temp_r;

endmodule

[design/tsa_alarm.sv]
// Window comparator with hysteresis and the armed flags that make entry and exit events one-shot.
// Depends on tsa_pkg and the assertion macro header.
`include "temp_sensor_average_window_alarm_unit_defines.svh"

module tsa_alarm
  import tsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              strobe,
  input  logic [TEMP_W-1:0] temp,
  input  win_cfg_t          win,
  output alarm_stat_t       stat
);

  localparam int CMP_W = TEMP_W + 2;

  logic signed [CMP_W-1:0] t_s, up_s, lo_s, h_s;
  logic signed [CMP_W-1:0] up_wide, lo_wide, up_narrow, lo_narrow;
  logic                    out_range, in_range;

  logic alarm_r, alarm_nxt;
  logic high_armed_r, high_armed_nxt;
  logic low_armed_r, low_armed_nxt;
  logic event_r, event_nxt;

  // Limits are compared at full precision, so two guard bits keep the sums exact.
  always_comb begin
    t_s       = $signed({{2{temp[TEMP_W-1]}}, temp});
    up_s      = $signed({{2{win.upper_limit[TEMP_W-1]}}, win.upper_limit});
    lo_s      = $signed({{2{win.lower_limit[TEMP_W-1]}}, win.lower_limit});
    h_s       = $signed({3'b000, win.hysteresis});
    up_wide   = up_s + h_s;
    lo_wide   = lo_s - h_s;
    up_narrow = up_s - h_s;
    lo_narrow = lo_s + h_s;
    out_range = (t_s > up_wide) || (t_s < lo_wide);
    in_range  = (t_s < up_narrow) && (t_s > lo_narrow);
  end

  // When the regions overlap, the out-of-range test takes priority.
  always_comb begin
    alarm_nxt      = alarm_r;
    high_armed_nxt = high_armed_r;
    low_armed_nxt  = low_armed_r;
    event_nxt      = event_r;
    if (strobe) begin
      event_nxt = 1'b0;
      if (out_range) begin
        if (high_armed_r) begin
          high_armed_nxt = 1'b0;
          low_armed_nxt  = 1'b1;
          alarm_nxt      = 1'b1;
          event_nxt      = 1'b1;
        end
      end else if (in_range) begin
        if (low_armed_r) begin
          low_armed_nxt  = 1'b0;
          high_armed_nxt = 1'b1;
          alarm_nxt      = 1'b0;
          event_nxt      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r      <= 1'b0;
      high_armed_r <= 1'b1;
      low_armed_r  <= 1'b1;
      event_r      <= 1'b0;
    end else begin
      alarm_r      <= alarm_nxt;
      high_armed_r <= high_armed_nxt;
      low_armed_r  <= low_armed_nxt;
      event_r      <= event_nxt;
    end
  end

  assign stat.active      = alarm_r;
  assign stat.range_event = event_r;

  `TSA_ASSERT_IMPLY(a_alarm_disarms_high, alarm_r, !high_armed_r && low_armed_r, "alarm set while high entry still armed")
  `TSA_ASSERT_NEXT(a_exit_sets_alarm, strobe && out_range && high_armed_r, alarm_r && event_r, "armed exit did not raise the alarm")
  `TSA_ASSERT_NEXT(a_entry_clears_alarm, strobe && !out_range && in_range && low_armed_r, !alarm_r && event_r, "armed entry did not clear the alarm")

endmodule

[design/temp_sensor_average_window_alarm_unit.sv]
// Temperature sensor front end: each ADC sample accepted on the input stream yields one
// result transaction with the converted temperature, the window alarm level and a one-shot
// range event, and every SAMPLES_PER_AVG samples also the converted block average (flagged
// by out_tuser). Samples are handled one at a time. A result is formed by the 16-step
// bit-serial gain multiplier plus the saturation, capture, compare and output steps. For a
// sample that completes a window, the 18-step serial divider forms the average while the
// sample itself converts, and the same multiplier then converts the average. A new sample
// is accepted as soon as the previous one has been placed in the output register, even
// while that result still waits for out_tready; the next result then waits in its output
// step until the register frees up. Configuration writes are expected only while the block
// is idle. Depends on tsa_pkg, tsa_conv, tsa_div and tsa_alarm.
`include "temp_sensor_average_window_alarm_unit_defines.svh"

module temp_sensor_average_window_alarm_unit
  import tsa_pkg::*;
#(
  parameter int SAMPLES_PER_AVG = 8,
  parameter int ADC_BITS        = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] adc_sample, [15:10] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [16:0] inst_temp, [33:17] avg_temp,
                                            // [34] alarm_active, [35] range_event, [39:36] zero
  output logic                  out_tuser,  // [0] avg_valid
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The sample counter needs at least one bit even for a window of one.
  localparam int CNT_W = (SAMPLES_PER_AVG > 1) ? $clog2(SAMPLES_PER_AVG) : 1;
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_AVG - 1);

  // Configuration registers.
  logic              sensor_type_r, sensor_type_nxt;
  logic [GAIN_W-1:0] gain_q8_r, gain_q8_nxt;
  logic [TEMP_W-1:0] offset_t_r, offset_t_nxt;
  logic [TEMP_W-1:0] upper_limit_r, upper_limit_nxt;
  logic [TEMP_W-1:0] lower_limit_r, lower_limit_nxt;
  logic [HYST_W-1:0] hysteresis_r, hysteresis_nxt;

  // Sequencer and datapath state.
  tsa_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              win_r, win_nxt;
  logic [TEMP_W-1:0] inst_r, inst_nxt;
  logic [TEMP_W-1:0] avg_r, avg_nxt;
  out_pay_t          out_pay_r, out_pay_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_avg_valid_r, out_avg_valid_nxt;

  logic                accept;
  logic [ADC_BITS-1:0] reading_in;
  logic                window_hit;
  logic [SUM_W-1:0]    sum_new;

  logic                ready_int;
  logic                conv_start;
  logic [ADC_BITS-1:0] conv_reading;
  logic                conv_done;
  logic [TEMP_W-1:0]   conv_temp;
  logic                div_start;
  logic                div_busy;
  logic [SUM_W-1:0]    div_quot;
  logic                alarm_strobe;
  logic                out_load;

  cal_cfg_t            cal;
  win_cfg_t            win;
  alarm_stat_t         alarm_stat;

  // Only the low ADC_BITS bits of the sample are significant.
  assign reading_in = ADC_BITS'(in_tdata[SAMPLE_W-1:0]);
  assign accept     = in_tvalid && ready_int;
  assign window_hit = (count_r == LAST_COUNT);
  assign sum_new    = sum_r + SUM_W'(reading_in);

  assign cal.sensor_type = sensor_type_r;
  assign cal.gain_q8     = gain_q8_r;
  assign cal.offset_t    = offset_t_r;
  assign win.upper_limit = upper_limit_r;
  assign win.lower_limit = lower_limit_r;
  assign win.hysteresis  = hysteresis_r;

  // Configuration write decoder; writes to unknown indexes are dropped.
  always_comb begin
    sensor_type_nxt = sensor_type_r;
    gain_q8_nxt     = gain_q8_r;
    offset_t_nxt    = offset_t_r;
    upper_limit_nxt = upper_limit_r;
    lower_limit_nxt = lower_limit_r;
    hysteresis_nxt  = hysteresis_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_SENSOR_TYPE: sensor_type_nxt = cfg_wdata[0];
        REG_GAIN_Q8:     gain_q8_nxt     = cfg_wdata[GAIN_W-1:0];
        REG_OFFSET_T:    offset_t_nxt    = cfg_wdata;
        REG_UPPER_LIMIT: upper_limit_nxt = cfg_wdata;
        REG_LOWER_LIMIT: lower_limit_nxt = cfg_wdata;
        REG_HYSTERESIS:  hysteresis_nxt  = cfg_wdata[HYST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Next state. A sample runs: convert, compare, optionally divide and convert
  // the average, then wait for the output register.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_INST;
      S_INST: if (conv_done) state_nxt = S_CMP;
      S_CMP:  state_nxt = win_r ? S_DIV : S_OUT;
      S_DIV:  if (!div_busy) state_nxt = S_AVG;
      S_AVG:  if (conv_done) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ready_int    = 1'b0;
    conv_start   = 1'b0;
    conv_reading = reading_in;
    alarm_strobe = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ready_int  = 1'b1;
        conv_start = in_tvalid;
      end
      S_INST: begin
      end
      S_CMP: alarm_strobe = 1'b1;
      S_DIV: begin
        // The average of a window never exceeds the reading range, so the low
        // quotient bits carry it whole.
        conv_start   = !div_busy;
        conv_reading = div_quot[ADC_BITS-1:0];
      end
      S_AVG: begin
      end
      S_OUT: out_load = !out_valid_r || out_tready;
      default: begin
      end
    endcase
  end

  assign div_start = accept && window_hit;

  // Window accumulation and result staging.
  always_comb begin
    sum_nxt           = sum_r;
    count_nxt         = count_r;
    win_nxt           = win_r;
    inst_nxt          = inst_r;
    avg_nxt           = avg_r;
    out_pay_nxt       = out_pay_r;
    out_avg_valid_nxt = out_avg_valid_r;
    out_valid_nxt     = out_valid_r && !out_tready;

    if (accept) begin
      if (window_hit) begin
        sum_nxt   = '0;
        count_nxt = '0;
        win_nxt   = 1'b1;
      end else begin
        sum_nxt   = sum_new;
        count_nxt = count_r + CNT_W'(1);
        win_nxt   = 1'b0;
      end
    end

    if (state_r == S_INST && conv_done) begin
      inst_nxt = conv_temp;
    end
    if (state_r == S_AVG && conv_done) begin
      avg_nxt = conv_temp;
    end

    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_avg_valid_nxt        = win_r;
      out_pay_nxt.pad          = '0;
      out_pay_nxt.range_event  = alarm_stat.range_event;
      out_pay_nxt.alarm_active = alarm_stat.active;
      out_pay_nxt.avg_temp     = win_r ? avg_r : '0;
      out_pay_nxt.inst_temp    = inst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_type_r <= 1'b0;
      gain_q8_r     <= RST_GAIN_Q8;
      offset_t_r    <= '0;
      upper_limit_r <= RST_UPPER_LIMIT;
      lower_limit_r <= RST_LOWER_LIMIT;
      hysteresis_r  <= RST_HYSTERESIS;
      state_r       <= S_IDLE;
      sum_r         <= '0;
      count_r       <= '0;
      win_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      sensor_type_r <= sensor_type_nxt;
      gain_q8_r     <= gain_q8_nxt;
      offset_t_r    <= offset_t_nxt;
      upper_limit_r <= upper_limit_nxt;
      lower_limit_r <= lower_limit_nxt;
      hysteresis_r  <= hysteresis_nxt;
      state_r       <= state_nxt;
      sum_r         <= sum_nxt;
      count_r       <= count_nxt;
      win_r         <= win_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    inst_r          <= inst_nxt;
    avg_r           <= avg_nxt;
    out_pay_r       <= out_pay_nxt;
    out_avg_valid_r <= out_avg_valid_nxt;
  end

  tsa_conv #(
    .ADC_BITS (ADC_BITS)
  ) u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (conv_start),
    .reading (conv_reading),
    .cal     (cal),
    .done    (conv_done),
    .temp    (conv_temp)
  );

  tsa_div #(
    .SAMPLES_PER_AVG (SAMPLES_PER_AVG)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_new),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  tsa_alarm u_alarm (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (alarm_strobe),
    .temp   (inst_r),
    .win    (win),
    .stat   (alarm_stat)
  );

  assign in_tready  = ready_int;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pay_r;
  assign out_tuser  = out_avg_valid_r;

  `TSA_ASSERT_IMPLY(a_div_idle_when_idle, state_r == S_IDLE, !div_busy, "divider still busy with no sample in work")
  `TSA_ASSERT_IMPLY(a_count_in_window, 1'b1, count_r <= LAST_COUNT, "sample count ran past the window length")
  `TSA_ASSERT_IMPLY(a_avg_zero_unflagged, out_valid_r && !out_avg_valid_r, out_pay_r.avg_temp == '0, "average field not zero without a completed window")

endmodule

[bench/temp_sensor_average_window_alarm_unit_test.sv]
// Self-checking bench for the temperature averaging and window alarm unit.
// Drives sample and register traffic, predicts every result transaction and compares
// them in order. Depends on tsa_pkg and temp_sensor_average_window_alarm_unit.
module temp_sensor_average_window_alarm_unit_test
  import tsa_pkg::*;
();

  localparam int AVG_WINDOW      = 8;
  localparam int ADC_W           = 10;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int NUM_PHASES      = 9;
  localparam int RX_HOLD_CYCLES  = 300;
  // Leave room for a stray result.
  localparam int SETTLE_CYCLES   = 80;
  // Far above the slowest legal run: about 650 samples, plus random gaps on both
  // sides and the long receiver hold-off.
  localparam int TIMEOUT_UNITS   = 4000000;

  // Addresses that decode to no register; writes there must change nothing.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

  // One result transaction as the bench predicts it.
  typedef struct packed {
    logic [TEMP_W-1:0] inst_temp;
    logic [TEMP_W-1:0] avg_temp;
    logic              avg_valid;
    logic              alarm_active;
    logic              range_event;
  } temp_report_t;

  typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  // One step of the directed sequence: either a register write or a sample. A sample
  // row may carry a hand-written report; otherwise the predictor supplies it.
  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] reg_addr;
    logic [CFG_DATA_W-1:0] value;
    bit                    known;
    temp_report_t          report;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [9:0] adc_sample, [15:10] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [16:0] inst_temp, [33:17] avg_temp,
                                            // [34] alarm_active, [35] range_event, [39:36] zero
  logic                  out_tuser;         // [0] avg_valid
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Calibration and window settings as the predictor believes them to be. They start
  // at the reset values of the block and follow every register write.
  logic                     cal_sensor_type = 1'b0;
  logic [GAIN_W-1:0]        cal_gain        = RST_GAIN_Q8;
  logic signed [TEMP_W-1:0] cal_offset      = '0;
  logic signed [TEMP_W-1:0] win_upper       = RST_UPPER_LIMIT;
  logic signed [TEMP_W-1:0] win_lower       = RST_LOWER_LIMIT;
  logic [HYST_W-1:0]        win_hyst        = RST_HYSTERESIS;

  // Averaging and comparator state of the predictor. Both entries are armed after
  // reset, so the very first sample in or out of the window raises an event.
  logic [SUM_W-1:0] acc_sum     = '0;
  int               acc_count   = 0;
  logic             alarm_level = 1'b0;
  logic             high_armed  = 1'b1;
  logic             low_armed   = 1'b1;

  temp_report_t pending_reports[$];
  int           samples_sent   = 0;
  int           results_seen   = 0;
  int           mismatch_count = 0;

  // Percentages of cycles in which each side holds back; changed per phase.
  int sender_idle_pct = 24;
  int rx_idle_pct     = 48;

  // The stimulus process asks for a long receiver hold-off by bumping hold_requests;
  // the receiver counts the stretch out itself.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  always #5 clk = ~clk;

  temp_sensor_average_window_alarm_unit #(
    .SAMPLES_PER_AVG(AVG_WINDOW),
    .ADC_BITS       (ADC_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Converts a reading (a raw sample or a window average) to 1/256 degree units.
  // The gain product is floored by the arithmetic shift, then the offset is added
  // and the sum is clamped to the signed 17-bit range.
  function automatic logic [TEMP_W-1:0] to_temperature(logic [SUM_W-1:0] reading);
    longint base;
    longint scaled;
    base = (longint'(reading) * BASE_SCALE) >>> ADC_W;
    if (cal_sensor_type) begin
      base -= HALF_SCALE;
    end
    scaled = ((base * longint'(cal_gain)) >>> 8) + longint'(cal_offset);
    if (scaled > 65535) begin
      scaled = 65535;
    end
    if (scaled < -65536) begin
      scaled = -65536;
    end
    return scaled[TEMP_W-1:0];
  endfunction

  // Advances the predictor by one accepted sample and returns the report it causes.
  function automatic temp_report_t predict_report(logic [ADC_W-1:0] sample);
    temp_report_t r;
    longint       t;
    longint       up;
    longint       lo;
    longint       h;
    r = '0;
    r.inst_temp = to_temperature(SUM_W'(sample));

    acc_sum   = acc_sum + SUM_W'(sample);
    acc_count = acc_count + 1;
    if (acc_count >= AVG_WINDOW) begin
      r.avg_temp  = to_temperature(SUM_W'(acc_sum / AVG_WINDOW));
      r.avg_valid = 1'b1;
      acc_sum     = '0;
      acc_count   = 0;
    end

    // Limits are widened or narrowed by the band at full precision, so nothing wraps.
    // When the two regions overlap, the out-of-range test is taken first.
    t  = longint'(signed'(r.inst_temp));
    up = longint'(win_upper);
    lo = longint'(win_lower);
    h  = longint'(win_hyst);
    if (t > up + h || t < lo - h) begin
      if (high_armed) begin
        high_armed    = 1'b0;
        low_armed     = 1'b1;
        alarm_level   = 1'b1;
        r.range_event = 1'b1;
      end
    end else if (t < up - h && t > lo + h) begin
      if (low_armed) begin
        low_armed     = 1'b0;
        high_armed    = 1'b1;
        alarm_level   = 1'b0;
        r.range_event = 1'b1;
      end
    end
    r.alarm_active = alarm_level;
    return r;
  endfunction

  function automatic stim_row_t sample_row(int unsigned sample);
    stim_row_t row;
    row = '{ROW_SAMPLE, REG_SENSOR_TYPE, CFG_DATA_W'(sample), 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t known_row(int unsigned sample, temp_report_t report);
    stim_row_t row;
    row = '{ROW_SAMPLE, REG_SENSOR_TYPE, CFG_DATA_W'(sample), 1'b1, report};
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] addr,
                                        logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = '{ROW_CONFIG, addr, value, 1'b0, '0};
    return row;
  endfunction

  // Writes one register and mirrors it into the predictor. The enable stays high
  // until the next sample is offered, so back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    case (addr)
      REG_SENSOR_TYPE: cal_sensor_type = value[0];
      REG_GAIN_Q8:     cal_gain        = value[GAIN_W-1:0];
      REG_OFFSET_T:    cal_offset      = value;
      REG_UPPER_LIMIT: win_upper       = value;
      REG_LOWER_LIMIT: win_lower       = value;
      REG_HYSTERESIS:  win_hyst        = value[HYST_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one sample, waits for its input transaction, and queues the report that
  // must come back for it. A row with a hand-written report still steps the predictor
  // so that its state stays in line with the block.
  task automatic send_sample(input logic [ADC_W-1:0] sample, input bit known,
                             input temp_report_t report);
    temp_report_t predicted;
    if (cfg_we) begin
      cfg_we <= 1'b0;
    end
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(sample);
    do @(posedge clk); while (!in_tready);
    predicted = predict_report(sample);
    pending_reports.push_back(known ? report : predicted);
    samples_sent++;
  endtask

  // Stops offering samples and waits until every queued report has been seen.
  // Always lets at least one edge pass, so it never stacks drives with the caller.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen != samples_sent);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request. During the
  // hold-off the sender keeps offering, so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= RX_HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result checker. Every result transaction is compared with the oldest queued
  // report; a result with nothing queued is an error as well.
  always @(posedge clk) begin : check_results
    temp_report_t want;
    out_pay_t     got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_pay_t'(out_tdata);
      results_seen++;
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: inst=%0d avg=%0d valid=%0b alarm=%0b event=%0b",
                   $signed(got.inst_temp), $signed(got.avg_temp), out_tuser,
                   got.alarm_active, got.range_event);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got.inst_temp !== want.inst_temp || got.avg_temp !== want.avg_temp ||
            out_tuser !== want.avg_valid || got.alarm_active !== want.alarm_active ||
            got.range_event !== want.range_event) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d mismatch: expected inst=%0d avg=%0d valid=%0b alarm=%0b event=%0b",
                     results_seen, $signed(want.inst_temp), $signed(want.avg_temp),
                     want.avg_valid, want.alarm_active, want.range_event);
            $display("  got inst=%0d avg=%0d valid=%0b alarm=%0b event=%0b",
                     $signed(got.inst_temp), $signed(got.avg_temp), out_tuser,
                     got.alarm_active, got.range_event);
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    stim_row_t        directed_rows[$];
    int               style;
    int               lo_lim;
    int               hi_lim;
    int               pick;
    int               walk;
    logic [ADC_W-1:0] sample;

    // Directed part. The first three reports are plain from the reset settings: a zero
    // reading is below the window and, with both entries armed, raises the alarm; full
    // scale is still out of range but raises no second event; 5000 is back inside.
    directed_rows = '{
      known_row(0,    temp_report_t'{17'd0,     17'd0, 1'b0, 1'b1, 1'b1}),
      known_row(1023, temp_report_t'{17'd25575, 17'd0, 1'b0, 1'b1, 1'b0}),
      known_row(200,  temp_report_t'{17'd5000,  17'd0, 1'b0, 1'b0, 1'b1}),
      // Walk through the hysteresis band and out again; the eighth sample closes a window.
      sample_row(300), sample_row(320), sample_row(100), sample_row(50), sample_row(200),
      // Offset sensor with maximum gain and minimum offset: both saturation rails.
      reg_row(REG_SENSOR_TYPE, 17'd1),
      reg_row(REG_GAIN_Q8,     17'd65535),
      reg_row(REG_OFFSET_T,    17'h10000),
      sample_row(0), sample_row(1023), sample_row(512),
      // Zero gain leaves only the offset, here the largest one.
      reg_row(REG_GAIN_Q8,     17'd0),
      reg_row(REG_OFFSET_T,    17'h0FFFF),
      sample_row(1023),
      // Crossed limits: the two regions overlap and the out-of-range test must win.
      reg_row(REG_GAIN_Q8,     17'd256),
      reg_row(REG_OFFSET_T,    17'd0),
      reg_row(REG_SENSOR_TYPE, 17'd0),
      reg_row(REG_UPPER_LIMIT, 17'h10000),
      reg_row(REG_LOWER_LIMIT, 17'h0FFFF),
      reg_row(REG_HYSTERESIS,  17'd0),
      sample_row(400), sample_row(1023),
      // Writes to addresses that hold no register are ignored.
      reg_row(REG_SPARE_6,     17'h1FFFF),
      reg_row(REG_SPARE_7,     17'h1FFFF),
      sample_row(600),
      // Widest window with the widest band.
      reg_row(REG_UPPER_LIMIT, 17'h0FFFF),
      reg_row(REG_LOWER_LIMIT, 17'h10000),
      reg_row(REG_HYSTERESIS,  17'd65535),
      sample_row(0), sample_row(1023), sample_row(512),
      // Negative products that are not multiples of 256 must round toward minus infinity.
      reg_row(REG_SENSOR_TYPE, 17'd1),
      reg_row(REG_GAIN_Q8,     17'd257),
      reg_row(REG_UPPER_LIMIT, 17'd7680),
      reg_row(REG_LOWER_LIMIT, 17'd2560),
      reg_row(REG_HYSTERESIS,  17'd256),
      sample_row(1), sample_row(1022)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        // Registers only change while nothing is in flight.
        wait_for_results();
        write_reg(directed_rows[i].reg_addr, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value[ADC_W-1:0], directed_rows[i].known,
                    directed_rows[i].report);
      end
    end

    // Random part. Each phase picks a fresh setting and then feeds a slow random walk
    // of readings, so the temperature drifts across the window edges and drives the
    // alarm through all of its transitions, with some full-range and rail samples mixed in.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // First the sender idles less than the receiver, then the reverse, then neither.
      case (phase / 3)
        0: begin
          sender_idle_pct = 24;
          rx_idle_pct     = 48;
        end
        1: begin
          sender_idle_pct = 48;
          rx_idle_pct     = 24;
        end
        default: begin
          sender_idle_pct = 0;
          rx_idle_pct     = 0;
        end
      endcase

      wait_for_results();
      style = (phase == 0) ? 0 : $urandom_range(0, 3);
      write_reg(REG_SENSOR_TYPE, CFG_DATA_W'($urandom_range(0, 1)));
      if (style <= 1) begin
        // A realistic calibration and a window that the readings actually cross.
        lo_lim = int'($urandom_range(0, 15000)) - 6000;
        hi_lim = lo_lim + int'($urandom_range(0, 8000));
        write_reg(REG_GAIN_Q8,     CFG_DATA_W'($urandom_range(192, 320)));
        write_reg(REG_OFFSET_T,    CFG_DATA_W'(int'($urandom_range(0, 2048)) - 1024));
        write_reg(REG_UPPER_LIMIT, CFG_DATA_W'(hi_lim));
        write_reg(REG_LOWER_LIMIT, CFG_DATA_W'(lo_lim));
        write_reg(REG_HYSTERESIS,  CFG_DATA_W'($urandom_range(0, 512)));
      end else if (style == 2) begin
        write_reg(REG_GAIN_Q8,     CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_OFFSET_T,    CFG_DATA_W'($urandom));
        write_reg(REG_UPPER_LIMIT, CFG_DATA_W'($urandom));
        write_reg(REG_LOWER_LIMIT, CFG_DATA_W'($urandom));
        write_reg(REG_HYSTERESIS,  CFG_DATA_W'($urandom_range(0, 65535)));
      end else begin
        // Every register at one of its extremes.
        write_reg(REG_GAIN_Q8,     $urandom_range(0, 1) ? 17'd65535 : 17'd0);
        write_reg(REG_OFFSET_T,    $urandom_range(0, 1) ? 17'h0FFFF : 17'h10000);
        write_reg(REG_UPPER_LIMIT, $urandom_range(0, 1) ? 17'h0FFFF : 17'h10000);
        write_reg(REG_LOWER_LIMIT, $urandom_range(0, 1) ? 17'h0FFFF : 17'h10000);
        write_reg(REG_HYSTERESIS,  $urandom_range(0, 1) ? 17'd65535 : 17'd0);
      end

      walk = $urandom_range(0, 1023);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // One long receiver hold-off while samples keep coming.
        if (phase == 1 && n == 20) begin
          hold_requests++;
        end
        // One pause of the sender until every result is back.
        if (phase == 4 && n == 35) begin
          wait_for_results();
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          walk = walk + int'($urandom_range(0, 48)) - 24;
          if (walk < 0) begin
            walk = 0;
          end
          if (walk > 1023) begin
            walk = 1023;
          end
          sample = ADC_W'(walk);
        end else if (pick < 90) begin
          sample = ADC_W'($urandom_range(0, 1023));
        end else begin
          sample = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        end
        send_sample(sample, 1'b0, '0);
      end
    end

    // Drain, then give a stray late result the chance to show up before the verdict.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
